[rtl/core/ajd_pkg.sv]
// Shared types and constants for the analog joystick direction decoder.
`timescale 1ns / 1ps

package ajd_pkg;

	localparam int PCT_FULL = 100;

	typedef enum logic [2:0] {
		REG_X_CENTER      = 3'd0,
		REG_X_LEFT_LIMIT  = 3'd1,
		REG_X_RIGHT_LIMIT = 3'd2,
		REG_Y_CENTER      = 3'd3,
		REG_Y_UPPER_LIMIT = 3'd4,
		REG_Y_LOWER_LIMIT = 3'd5,
		REG_THRESHOLD     = 3'd6,
		REG_ENABLED       = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_PRESS   = 2'd1,
		EV_HOLD    = 2'd2,
		EV_RELEASE = 2'd3
	} btn_ev_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic last;
	} ctrl_t;

endpackage

[rtl/core/ajd_if.sv]
// Item channel interfaces for joystick readings and decoded results.
`timescale 1ns / 1ps

interface ajd_in_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] x_sample;
	logic signed [SAMPLE_BITS-1:0] y_sample;
	logic                          button_one;
	logic                          button_two;
	logic                          read_ok;

	modport source (
		output valid, x_sample, y_sample, button_one, button_two, read_ok,
		input  ready
	);
	modport sink (
		input  valid, x_sample, y_sample, button_one, button_two, read_ok,
		output ready
	);
endinterface

interface ajd_out_if;
	logic       valid;
	logic       ready;
	logic [5:0] action_mask;
	logic [1:0] button_event;
	logic       device_available;

	modport source (
		output valid, action_mask, button_event, device_available,
		input  ready
	);
	modport sink (
		input  valid, action_mask, button_event, device_available,
		output ready
	);
endinterface

[rtl/core/ajd_bit_sub.sv]
// Bit-serial subtractor, LSB first, one difference bit per step.
`timescale 1ns / 1ps

module ajd_bit_sub
	import ajd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  ctrl_t ctrl,
	input  logic  a_bit,
	input  logic  b_bit,
	output logic  d_bit
);

	logic borrow_q;

	assign d_bit = a_bit ^ b_bit ^ borrow_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			borrow_q <= 1'b0;
		end else if (ctrl.load) begin
			borrow_q <= 1'b0;
		end else if (ctrl.step) begin
			borrow_q <= (~a_bit & b_bit) | (~(a_bit ^ b_bit) & borrow_q);
		end
	end

endmodule

[rtl/core/ajd_dir_cmp.sv]
// Bit-serial threshold compare of one direction: sign of pos*100 - k*range.
`timescale 1ns / 1ps

module ajd_dir_cmp
	import ajd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  ctrl_t      ctrl,
	input  logic       da_bit,
	input  logic       dl_bit,
	input  logic [7:0] k,
	output logic       hit
);

	logic signed [9:0] term;
	logic signed [9:0] sum;
	logic signed [8:0] carry_q;
	logic              ez_q;
	logic              nz_q;
	logic              hit_q;
	logic              e_le0;
	logic              e_ge0;
	logic              hit_d;

	always_comb begin
		term = '0;
		if (da_bit) begin
			term = term + 10'(PCT_FULL);
		end
		if (dl_bit) begin
			term = term - signed'({2'b00, k});
		end
		if (ctrl.last) begin
			term = -term;
		end
		sum   = {carry_q[8], carry_q} + term;
		e_ge0 = ~sum[9];
		e_le0 = sum[9] | ((sum == '0) & ez_q);
		hit_d = (nz_q | dl_bit) & (dl_bit ? e_le0 : e_ge0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= '0;
			ez_q    <= 1'b1;
			nz_q    <= 1'b0;
			hit_q   <= 1'b0;
		end else if (ctrl.load) begin
			carry_q <= '0;
			ez_q    <= 1'b1;
			nz_q    <= 1'b0;
		end else if (ctrl.step) begin
			carry_q <= sum[9:1];
			ez_q    <= ez_q & ~sum[0];
			nz_q    <= nz_q | dl_bit;
			if (ctrl.last) begin
				hit_q <= hit_d;
			end
		end
	end

	assign hit = hit_q;

endmodule

[rtl/core/analog_joystick_direction_decoder_core.sv]
// Top level of the analog joystick direction decoder.
`timescale 1ns / 1ps
// Usage: one reading enters per item on in_ch (valid/ready); one result per
// reading leaves on out_ch (valid/ready). Calibration must be written through
// cfg_we/cfg_index/cfg_data while no item is in flight; the block itself does not enforce this.
// Each reading is decoded bit-serially: all operands shift out LSB first,
// six serial subtractors form the offsets of the readings and limits from
// centre and four serial compare units weigh them against the threshold,
// one bit per cycle.
// A new item is taken only in the idle state, once the previous result has
// moved into the output register.
// A finished result sits in an output register, so the next item is taken
// while it waits; if the receiver stalls longer, the finished item holds
// until the register frees.
// Reset loads the calibration defaults, clears the button history and
// marks the device available; no item or result is pending.
module analog_joystick_direction_decoder_core
	import ajd_pkg::*;
#(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	ajd_in_if.sink                 in_ch,
	ajd_out_if.source              out_ch,
	input  logic                   cfg_we,
	input  logic [2:0]             cfg_index,
	input  logic [SAMPLE_BITS-1:0] cfg_data
);

	localparam int CW = $clog2(SAMPLE_BITS + 1);
	localparam logic signed [SAMPLE_BITS-1:0] LIM_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] LIM_MIN = -LIM_MAX;

	logic signed [SAMPLE_BITS-1:0] x_center_q, x_left_q, x_right_q;
	logic signed [SAMPLE_BITS-1:0] y_center_q, y_upper_q, y_lower_q;
	logic [6:0]                    thr_q;
	logic                          enabled_q;

	logic signed [SAMPLE_BITS-1:0] sh_xs_q, sh_ys_q, sh_xc_q, sh_yc_q;
	logic signed [SAMPLE_BITS-1:0] sh_xl_q, sh_xr_q, sh_yu_q, sh_yd_q;
	logic                          b1_q, b2_q, rok_q;

	state_t        state_q, state_d;
	logic [CW-1:0] cnt_q;
	ctrl_t         ctrl;
	logic          in_acc;
	logic          done_fire;
	logic          last_held_q;
	logic          unavail_q;

	logic       out_valid_q;
	logic [5:0] out_mask_q;
	logic [1:0] out_ev_q;
	logic       out_avail_q;

	logic       da_x, da_y, dl_l, dl_r, dl_u, dl_d;
	logic       hit_l, hit_r, hit_u, hit_d;
	logic [7:0] k;

	logic       active;
	logic       unavail_d;
	logic [5:0] mask_d;
	logic       held_d;
	btn_ev_t    ev_d;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_center_q <= '0;
			x_left_q   <= LIM_MIN;
			x_right_q  <= LIM_MAX;
			y_center_q <= '0;
			y_upper_q  <= LIM_MIN;
			y_lower_q  <= LIM_MAX;
			thr_q      <= 7'd25;
			enabled_q  <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_X_CENTER:      x_center_q <= cfg_data;
				REG_X_LEFT_LIMIT:  x_left_q   <= cfg_data;
				REG_X_RIGHT_LIMIT: x_right_q  <= cfg_data;
				REG_Y_CENTER:      y_center_q <= cfg_data;
				REG_Y_UPPER_LIMIT: y_upper_q  <= cfg_data;
				REG_Y_LOWER_LIMIT: y_lower_q  <= cfg_data;
				REG_THRESHOLD:     thr_q      <= cfg_data[6:0];
				REG_ENABLED:       enabled_q  <= cfg_data[0];
				default:           ;
			endcase
		end
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_ch.valid) begin
					state_d = S_RUN;
				end
			end
			S_RUN: begin
				if (cnt_q == CW'(SAMPLE_BITS)) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ch.ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ch.ready = 1'b0;
		ctrl        = '0;
		done_fire   = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ch.ready = 1'b1;
				ctrl.load   = in_ch.valid;
			end
			S_RUN: begin
				ctrl.step = 1'b1;
				ctrl.last = (cnt_q == CW'(SAMPLE_BITS));
			end
			S_DONE: begin
				done_fire = !out_valid_q || out_ch.ready;
			end
			default: ;
		endcase
	end

	assign in_acc = ctrl.load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				cnt_q <= '0;
			end else if (ctrl.step) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// operand shift registers, arithmetic shift keeps the sign bit for the extension step
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sh_xs_q <= in_ch.x_sample;
			sh_ys_q <= in_ch.y_sample;
			sh_xc_q <= x_center_q;
			sh_yc_q <= y_center_q;
			sh_xl_q <= x_left_q;
			sh_xr_q <= x_right_q;
			sh_yu_q <= y_upper_q;
			sh_yd_q <= y_lower_q;
			b1_q    <= in_ch.button_one;
			b2_q    <= in_ch.button_two;
			rok_q   <= in_ch.read_ok;
		end else if (ctrl.step) begin
			sh_xs_q <= sh_xs_q >>> 1;
			sh_ys_q <= sh_ys_q >>> 1;
			sh_xc_q <= sh_xc_q >>> 1;
			sh_yc_q <= sh_yc_q >>> 1;
			sh_xl_q <= sh_xl_q >>> 1;
			sh_xr_q <= sh_xr_q >>> 1;
			sh_yu_q <= sh_yu_q >>> 1;
			sh_yd_q <= sh_yd_q >>> 1;
		end
	end

	ajd_bit_sub u_sub_xa (.clk, .arst_n, .ctrl, .a_bit(sh_xs_q[0]), .b_bit(sh_xc_q[0]), .d_bit(da_x));
	ajd_bit_sub u_sub_ya (.clk, .arst_n, .ctrl, .a_bit(sh_ys_q[0]), .b_bit(sh_yc_q[0]), .d_bit(da_y));
	ajd_bit_sub u_sub_l  (.clk, .arst_n, .ctrl, .a_bit(sh_xl_q[0]), .b_bit(sh_xc_q[0]), .d_bit(dl_l));
	ajd_bit_sub u_sub_r  (.clk, .arst_n, .ctrl, .a_bit(sh_xr_q[0]), .b_bit(sh_xc_q[0]), .d_bit(dl_r));
	ajd_bit_sub u_sub_u  (.clk, .arst_n, .ctrl, .a_bit(sh_yu_q[0]), .b_bit(sh_yc_q[0]), .d_bit(dl_u));
	ajd_bit_sub u_sub_d  (.clk, .arst_n, .ctrl, .a_bit(sh_yd_q[0]), .b_bit(sh_yc_q[0]), .d_bit(dl_d));

	assign k = {1'b0, thr_q} + 8'd1;

	ajd_dir_cmp u_cmp_l (.clk, .arst_n, .ctrl, .da_bit(da_x), .dl_bit(dl_l), .k, .hit(hit_l));
	ajd_dir_cmp u_cmp_r (.clk, .arst_n, .ctrl, .da_bit(da_x), .dl_bit(dl_r), .k, .hit(hit_r));
	ajd_dir_cmp u_cmp_u (.clk, .arst_n, .ctrl, .da_bit(da_y), .dl_bit(dl_u), .k, .hit(hit_u));
	ajd_dir_cmp u_cmp_d (.clk, .arst_n, .ctrl, .da_bit(da_y), .dl_bit(dl_d), .k, .hit(hit_d));

	// result assembly
	always_comb begin
		logic dir_ok;
		dir_ok    = (thr_q < 7'(PCT_FULL));
		active    = enabled_q && !unavail_q && rok_q;
		unavail_d = unavail_q || (enabled_q && !rok_q);
		mask_d    = '0;
		if (active) begin
			mask_d[0] = dir_ok && hit_l;
			mask_d[1] = dir_ok && hit_r && !hit_l;
			mask_d[2] = dir_ok && hit_u;
			mask_d[3] = dir_ok && hit_d && !hit_u;
			mask_d[4] = b1_q;
			mask_d[5] = b2_q;
		end
		held_d = |mask_d[5:4];
		if (held_d) begin
			ev_d = last_held_q ? EV_HOLD : EV_PRESS;
		end else begin
			ev_d = last_held_q ? EV_RELEASE : EV_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_held_q <= 1'b0;
			unavail_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (done_fire) begin
			last_held_q <= held_d;
			unavail_q   <= unavail_d;
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			out_mask_q  <= mask_d;
			out_ev_q    <= ev_d;
			out_avail_q <= !unavail_d;
		end
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.action_mask      = out_mask_q;
	assign out_ch.button_event     = out_ev_q;
	assign out_ch.device_available = out_avail_q;

	a_unavail_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		unavail_q |=> unavail_q)
		else $error("unavailable flag cleared");

	a_unavail_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_avail_q |-> out_mask_q == 6'd0)
		else $error("action reported while device unavailable");

	a_dir_priority: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_mask_q[0] && out_mask_q[1]) && !(out_mask_q[2] && out_mask_q[3]))
		else $error("opposite directions reported together");

	a_event_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_ev_q == EV_PRESS || out_ev_q == EV_HOLD) |-> out_mask_q[5:4] != 2'b00)
		else $error("press event without a held button");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RUN |-> cnt_q <= CW'(SAMPLE_BITS))
		else $error("bit counter overran");

endmodule
